[hw/rtl/mavg_pkg.sv]
// package for the moving average filter unit
// holds default sizes, the opcode and controller state types; no dependencies
`timescale 1ns / 1ps

package mavg_pkg;

   localparam int DEFAULT_MAX_WINDOW  = 64;
   localparam int DEFAULT_SAMPLE_BITS = 16;
   localparam int LENGTH_BITS         = 7;

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_CLEAR  = 1'b1
   } mavg_opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } mavg_state_type;

endpackage

[hw/rtl/moving_average_filter_unit.sv]
// moving average filter unit: sample ring in a synchronous ram, running sum,
// bit-serial divider by the window length; depends on mavg_pkg
`timescale 1ns / 1ps

// Moving average over the last window_length signed samples. A filter word
// reads the oldest sample from the ring ram, swaps in the new one, updates an
// exact running sum and divides it by the window length, truncating toward
// zero. The divider is restoring and retires one quotient bit per cycle over
// the SAMPLE_BITS + clog2(MAX_WINDOW) bit sum. A filter word passes through
// the update, setup, divide and finish states, and no new word is accepted
// until it is done; its result sits in an output register while the unit
// goes on with the next word, whose finish waits until that result is
// taken. A clear word gives no result. A clear word or a write of
// window_length empties the ring at once: no clearing pass runs, a wrap flag
// marks whether the ring entry at the write position holds a sample since the
// last clear (entries are written in order from position zero), and an unwritten
// entry reads as zero. window_length 0 acts as 1, values above MAX_WINDOW act
// as MAX_WINDOW. Write the length only while the unit is idle.
module moving_average_filter_unit #(
   parameter int MAX_WINDOW  = mavg_pkg::DEFAULT_MAX_WINDOW,
   parameter int SAMPLE_BITS = mavg_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_average,
   // window length register
   input  logic                                 csr_write_enable,
   input  logic [mavg_pkg::LENGTH_BITS-1:0]     csr_write_data
);
   import mavg_pkg::*;

   localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(SUM_W);

   // controller
   mavg_state_type state_ff, state_in;

   // architectural state
   logic [LEN_W-1:0]              len_ff, len_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic                          wrapped_ff, wrapped_in;

   // sample ring
   logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0]        rd_data_ff;

   // working registers
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          neg_ff, neg_in;
   logic [LEN_W:0]                rem_ff, rem_in;
   logic [SUM_W-1:0]              quo_ff, quo_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;

   // control decode
   logic take, take_filter, mem_we, fin_load, out_free;

   // datapath helpers
   logic [LEN_W-1:0]              csr_len;
   logic [POS_W-1:0]              pos_eff;
   logic [POS_W:0]                pos_inc;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic signed [SUM_W-1:0]       sum_upd;
   logic [SUM_W-1:0]              sum_mag;
   logic [LEN_W:0]                rem_shift;
   logic [SAMPLE_BITS-1:0]        quo_low;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign take        = req_valid && !req_stall;
   assign take_filter = take && (req_opcode == OP_FILTER);

   // length clamp at write time
   always_comb begin
      if (csr_write_data == '0) begin
         csr_len = LEN_W'(1);
      end else if (32'(csr_write_data) > MAX_WINDOW) begin
         csr_len = LEN_W'(MAX_WINDOW);
      end else begin
         csr_len = LEN_W'(csr_write_data);
      end
   end

   // position past the window reads as zero
   assign pos_eff    = (32'(pos_ff) >= 32'(len_ff)) ? '0 : pos_ff;
   assign pos_inc    = {1'b0, pos_ff} + (POS_W + 1)'(1);
   assign old_sample = wrapped_ff ? $signed(rd_data_ff) : '0;
   assign sum_upd    = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign rem_shift  = {rem_ff[LEN_W-1:0], quo_ff[SUM_W-1]};
   assign quo_low    = quo_ff[SAMPLE_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_filter) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (cnt_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      fin_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_UPDATE: mem_we    = 1'b1;
         ST_SETUP:  ;
         ST_DIVIDE: ;
         ST_FINISH: fin_load  = out_free;
         default:   ;
      endcase
   end

   // datapath next values
   always_comb begin
      len_in       = len_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      wrapped_in   = wrapped_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (take && (req_opcode == OP_CLEAR)) begin
               sum_in     = '0;
               pos_in     = '0;
               wrapped_in = 1'b0;
            end else if (take_filter) begin
               sample_in = req_sample;
               pos_in    = pos_eff;
            end
         end
         ST_UPDATE: begin
            sum_in = sum_upd;
            if (32'(pos_inc) >= 32'(len_ff)) begin
               pos_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               pos_in = pos_inc[POS_W-1:0];
            end
         end
         ST_SETUP: begin
            neg_in = sum_ff[SUM_W-1];
            quo_in = sum_mag;
            rem_in = '0;
            cnt_in = CNT_W'(SUM_W - 1);
         end
         ST_DIVIDE: begin
            // one restoring step per cycle
            if (rem_shift >= {1'b0, len_ff}) begin
               rem_in = rem_shift - {1'b0, len_ff};
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_FINISH: begin
            if (fin_load) begin
               avg_in       = neg_ff ? $signed(-quo_low) : $signed(quo_low);
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase

      // length write restarts the filter
      if (csr_write_enable) begin
         len_in     = csr_len;
         sum_in     = '0;
         pos_in     = '0;
         wrapped_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_W'(1);
         pos_ff       <= '0;
         sum_ff       <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      avg_ff    <= avg_in;
   end

   // ring ram: read at acceptance, write back in the cycle after
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[pos_ff] <= sample_ff;
      if (take_filter) rd_data_ff <= ring_mem[pos_eff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = avg_ff;

   // checks
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < 32'(len_ff))
      else $error("write position outside window");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      len_ff != '0)
      else $error("window length is zero");

   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < {1'b0, len_ff}))
      else $error("divider remainder not below divisor");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (take && (req_opcode == OP_CLEAR)) |=> (sum_ff == '0) && !wrapped_ff && (pos_ff == '0))
      else $error("clear word left state behind");

endmodule
